@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked implication checks. The synthesis view leaves them empty.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every rising edge outside reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ sv/m68kd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m68kd_pkg
// Shared types and codes for the 68000 subset instruction decoder.
// ----------------------------------------------------------------------------
package m68kd_pkg;

    // Mnemonic codes
    localparam logic [4:0] MN_INVALID = 5'd0;
    localparam logic [4:0] MN_UNKNOWN = 5'd1;
    localparam logic [4:0] MN_NOP     = 5'd2;
    localparam logic [4:0] MN_RTS     = 5'd3;
    localparam logic [4:0] MN_JMP     = 5'd4;
    localparam logic [4:0] MN_JSR     = 5'd5;
    localparam logic [4:0] MN_BRA     = 5'd6;
    localparam logic [4:0] MN_BSR     = 5'd7;
    localparam logic [4:0] MN_BCC     = 5'd8;
    localparam logic [4:0] MN_LEA     = 5'd9;
    localparam logic [4:0] MN_MOVEA   = 5'd10;
    localparam logic [4:0] MN_MOVEQ   = 5'd11;
    localparam logic [4:0] MN_MOVE    = 5'd12;
    localparam logic [4:0] MN_ADD     = 5'd13;
    localparam logic [4:0] MN_SUBQ    = 5'd14;
    localparam logic [4:0] MN_CLR     = 5'd15;
    localparam logic [4:0] MN_TST     = 5'd16;
    localparam logic [4:0] MN_CMPI    = 5'd17;
    localparam logic [4:0] MN_ANDI    = 5'd18;
    localparam logic [4:0] MN_BCLR    = 5'd19;
    localparam logic [4:0] MN_ANDISR  = 5'd20;

    // Operand forms
    localparam logic [3:0] FM_NONE      = 4'd0;
    localparam logic [3:0] FM_PCREL     = 4'd1;
    localparam logic [3:0] FM_AREG_IND  = 4'd2;
    localparam logic [3:0] FM_PCIDX_AN  = 4'd3;
    localparam logic [3:0] FM_D16_AN    = 4'd4;
    localparam logic [3:0] FM_AN_ABS    = 4'd5;
    localparam logic [3:0] FM_IMM_ABS   = 4'd6;
    localparam logic [3:0] FM_DN_ABS    = 4'd7;
    localparam logic [3:0] FM_ABS_DN    = 4'd8;
    localparam logic [3:0] FM_IMM_DN    = 4'd9;
    localparam logic [3:0] FM_DN_DN     = 4'd10;
    localparam logic [3:0] FM_DN        = 4'd11;
    localparam logic [3:0] FM_ABS       = 4'd12;

    // Fixed opcodes
    localparam logic [15:0] OP_NOP       = 16'h4E71;
    localparam logic [15:0] OP_RTS       = 16'h4E75;
    localparam logic [15:0] OP_JMP_ABS   = 16'h4EF9;
    localparam logic [15:0] OP_JSR_ABS   = 16'h4EB9;
    localparam logic [15:0] OP_JMP_PC    = 16'h4EFA;
    localparam logic [15:0] OP_JSR_PC    = 16'h4EBA;
    localparam logic [15:0] OP_MOVEA_IDX = 16'h207B;
    localparam logic [15:0] OP_BCLR_ABS  = 16'h08B9;
    localparam logic [15:0] OP_ANDI_SR   = 16'h027C;
    localparam logic [15:0] OP_MOVEW_IA  = 16'h33FC;
    localparam logic [15:0] OP_MOVEB_IA  = 16'h13FC;
    localparam logic [15:0] OP_ADD_DD    = 16'hD040;
    localparam logic [15:0] OP_CLRB_ABS  = 16'h4239;
    localparam logic [15:0] OP_CLRW_ABS  = 16'h4279;
    localparam logic [15:0] OP_CLRL_ABS  = 16'h42B9;
    localparam logic [15:0] OP_TSTB_ABS  = 16'h4A39;
    localparam logic [15:0] OP_TSTW_ABS  = 16'h4A79;
    localparam logic [15:0] OP_TSTL_ABS  = 16'h4AB9;

    // Opcode masks
    localparam logic [15:0] MSK_REG_LO   = 16'hFFF8;
    localparam logic [15:0] MSK_REG_HI   = 16'hF1FF;
    localparam logic [15:0] MSK_REG_BOTH = 16'hF1F8;
    localparam logic [15:0] MSK_SUBQ     = 16'hF138;
    localparam logic [15:0] MSK_CLR_DN   = 16'hFF38;

    typedef struct packed {
        logic [31:0] instr_address;
        logic        fetch_mapped;
        logic [15:0] opcode_word;
        logic [15:0] ext_word_one;
        logic [15:0] ext_word_two;
        logic [15:0] ext_word_three;
    } instr_t;

    typedef struct packed {
        logic [4:0]         mnemonic_code;
        logic [3:0]         length_bytes;
        logic [3:0]         addressing_form;
        logic [2:0]         operand_size;
        logic [2:0]         main_register;
        logic [2:0]         source_register;
        logic [3:0]         branch_condition;
        logic [31:0]        immediate_value;
        logic signed [15:0] displacement_value;
        logic [31:0]        target_address;
        logic [31:0]        absolute_address;
    } dec_t;

    // Decode result before the target add
    typedef struct packed {
        logic [4:0]         mn;
        logic [3:0]         len;
        logic [3:0]         form;
        logic [2:0]         size;
        logic [2:0]         reg_main;
        logic [2:0]         reg_src;
        logic [3:0]         cond;
        logic [31:0]        imm;
        logic signed [15:0] disp;
        logic [31:0]        absa;
        logic [31:0]        tgt_base;
        logic signed [16:0] tgt_off;
    } ctl_t;

    // Two-bit size field to byte count
    function automatic logic [2:0] size_bytes(input logic [1:0] sz);
        logic [2:0] r;
        begin
            r = (sz == 2'd2) ? 3'd4 : (sz == 2'd1) ? 3'd2 : 3'd1;
            return r;
        end
    endfunction

endpackage

@@ sv/m68kd_decode.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m68kd_decode
// Priority mask/match classification of one instruction window.
// ----------------------------------------------------------------------------
module m68kd_decode (
    input  m68kd_pkg::instr_t instr,
    output m68kd_pkg::ctl_t   ctl
);

    typedef enum logic [1:0] {
        TS_NONE,
        TS_LONG,
        TS_REL
    } tsel_t;

    logic [15:0] op;
    logic [15:0] e1;
    logic [31:0] l12;
    logic [31:0] l23;
    logic [2:0]  hr;
    logic [2:0]  lr;
    logic [1:0]  sz2;

    assign op  = instr.opcode_word;
    assign e1  = instr.ext_word_one;
    assign l12 = {instr.ext_word_one, instr.ext_word_two};
    assign l23 = {instr.ext_word_two, instr.ext_word_three};
    assign hr  = op[11:9];
    assign lr  = op[2:0];
    assign sz2 = op[7:6];

    always_comb
    begin
        m68kd_pkg::ctl_t    c;
        tsel_t              ts;
        logic signed [16:0] roff;
        c        = '0;
        ts       = TS_NONE;
        roff     = '0;
        c.mn     = m68kd_pkg::MN_UNKNOWN;
        c.len    = 4'd2;
        if (!instr.fetch_mapped)
        begin
            c.mn  = m68kd_pkg::MN_INVALID;
            c.len = 4'd0;
        end
        else if (op == m68kd_pkg::OP_NOP)
        begin
            c.mn = m68kd_pkg::MN_NOP;
        end
        else if (op == m68kd_pkg::OP_RTS)
        begin
            c.mn = m68kd_pkg::MN_RTS;
        end
        else if (op == m68kd_pkg::OP_JMP_ABS || op == m68kd_pkg::OP_JSR_ABS)
        begin
            c.mn  = (op == m68kd_pkg::OP_JMP_ABS) ? m68kd_pkg::MN_JMP : m68kd_pkg::MN_JSR;
            c.len = 4'd6;
            ts    = TS_LONG;
        end
        else if (op == m68kd_pkg::OP_JMP_PC || op == m68kd_pkg::OP_JSR_PC)
        begin
            c.mn   = (op == m68kd_pkg::OP_JMP_PC) ? m68kd_pkg::MN_JMP : m68kd_pkg::MN_JSR;
            c.len  = 4'd4;
            c.form = m68kd_pkg::FM_PCREL;
            c.disp = e1;
            ts     = TS_REL;
            roff   = {e1[15], e1};
        end
        else if ((op & m68kd_pkg::MSK_REG_LO) == 16'h4ED0)
        begin
            c.mn       = m68kd_pkg::MN_JMP;
            c.form     = m68kd_pkg::FM_AREG_IND;
            c.reg_main = lr;
        end
        else if (op[15:12] == 4'h6)
        begin
            // BRA and BSR are condition codes zero and one
            c.mn = (op[11:8] == 4'd0) ? m68kd_pkg::MN_BRA :
                   (op[11:8] == 4'd1) ? m68kd_pkg::MN_BSR : m68kd_pkg::MN_BCC;
            if (op[11:9] != 3'd0)
            begin
                c.cond = op[11:8];
            end
            ts = TS_REL;
            if (op[7:0] == 8'd0)
            begin
                c.len = 4'd4;
                roff  = {e1[15], e1};
            end
            else
            begin
                roff = {{9{op[7]}}, op[7:0]};
            end
        end
        else if (op[15:12] == 4'h7 && !op[8])
        begin
            c.mn       = m68kd_pkg::MN_MOVEQ;
            c.reg_main = hr;
            c.imm      = {{24{op[7]}}, op[7:0]};
        end
        else if ((op & m68kd_pkg::MSK_REG_HI) == 16'h41FA)
        begin
            c.mn       = m68kd_pkg::MN_LEA;
            c.len      = 4'd4;
            c.reg_main = hr;
            ts         = TS_REL;
            roff       = {e1[15], e1};
        end
        else if ((op & m68kd_pkg::MSK_REG_HI) == 16'h41F9)
        begin
            c.mn       = m68kd_pkg::MN_LEA;
            c.len      = 4'd6;
            c.reg_main = hr;
            ts         = TS_LONG;
        end
        else if (op == m68kd_pkg::OP_MOVEA_IDX)
        begin
            c.mn      = m68kd_pkg::MN_MOVEA;
            c.len     = 4'd4;
            c.size    = 3'd4;
            c.form    = m68kd_pkg::FM_PCIDX_AN;
            c.reg_src = e1[14:12];
            c.disp    = {{8{e1[7]}}, e1[7:0]};
            ts        = TS_REL;
            roff      = {{9{e1[7]}}, e1[7:0]};
        end
        else if (op == m68kd_pkg::OP_BCLR_ABS)
        begin
            c.mn   = m68kd_pkg::MN_BCLR;
            c.len  = 4'd8;
            c.imm  = {16'd0, e1};
            c.absa = l23;
        end
        else if (op == m68kd_pkg::OP_ANDI_SR)
        begin
            c.mn  = m68kd_pkg::MN_ANDISR;
            c.len = 4'd4;
            c.imm = {16'd0, e1};
        end
        else if ((op & m68kd_pkg::MSK_REG_LO) == 16'h0228)
        begin
            c.mn       = m68kd_pkg::MN_ANDI;
            c.len      = 4'd6;
            c.size     = 3'd1;
            c.form     = m68kd_pkg::FM_D16_AN;
            c.reg_main = lr;
            c.imm      = {24'd0, e1[7:0]};
            c.disp     = instr.ext_word_two;
        end
        else if ((op & m68kd_pkg::MSK_REG_LO) == 16'h23C8)
        begin
            c.mn       = m68kd_pkg::MN_MOVE;
            c.len      = 4'd6;
            c.size     = 3'd4;
            c.form     = m68kd_pkg::FM_AN_ABS;
            c.reg_main = lr;
            c.absa     = l12;
        end
        else if (op == m68kd_pkg::OP_MOVEW_IA)
        begin
            c.mn   = m68kd_pkg::MN_MOVE;
            c.len  = 4'd8;
            c.size = 3'd2;
            c.form = m68kd_pkg::FM_IMM_ABS;
            c.imm  = {16'd0, e1};
            c.absa = l23;
        end
        else if (op == m68kd_pkg::OP_MOVEB_IA)
        begin
            c.mn   = m68kd_pkg::MN_MOVE;
            c.len  = 4'd8;
            c.size = 3'd1;
            c.form = m68kd_pkg::FM_IMM_ABS;
            c.imm  = {24'd0, e1[7:0]};
            c.absa = l23;
        end
        else if ((op & m68kd_pkg::MSK_REG_LO) == 16'h13C0)
        begin
            c.mn       = m68kd_pkg::MN_MOVE;
            c.len      = 4'd6;
            c.size     = 3'd1;
            c.form     = m68kd_pkg::FM_DN_ABS;
            c.reg_main = lr;
            c.absa     = l12;
        end
        else if ((op & m68kd_pkg::MSK_REG_HI) == 16'h1039)
        begin
            c.mn       = m68kd_pkg::MN_MOVE;
            c.len      = 4'd6;
            c.size     = 3'd1;
            c.form     = m68kd_pkg::FM_ABS_DN;
            c.reg_main = hr;
            c.absa     = l12;
        end
        else if ((op & m68kd_pkg::MSK_REG_BOTH) == 16'h1028)
        begin
            c.mn       = m68kd_pkg::MN_MOVE;
            c.len      = 4'd4;
            c.size     = 3'd1;
            c.form     = m68kd_pkg::FM_D16_AN;
            c.reg_main = hr;
            c.reg_src  = lr;
            c.disp     = e1;
        end
        else if ((op & m68kd_pkg::MSK_REG_HI) == 16'h2039)
        begin
            c.mn       = m68kd_pkg::MN_MOVE;
            c.len      = 4'd6;
            c.size     = 3'd4;
            c.form     = m68kd_pkg::FM_ABS_DN;
            c.reg_main = hr;
            c.absa     = l12;
        end
        else if ((op & m68kd_pkg::MSK_REG_HI) == 16'h303C)
        begin
            c.mn       = m68kd_pkg::MN_MOVE;
            c.len      = 4'd4;
            c.size     = 3'd2;
            c.form     = m68kd_pkg::FM_IMM_DN;
            c.reg_main = hr;
            c.imm      = {16'd0, e1};
        end
        else if ((op & m68kd_pkg::MSK_REG_HI) == 16'h103C)
        begin
            c.mn       = m68kd_pkg::MN_MOVE;
            c.len      = 4'd4;
            c.size     = 3'd1;
            c.form     = m68kd_pkg::FM_IMM_DN;
            c.reg_main = hr;
            c.imm      = {24'd0, e1[7:0]};
        end
        else if ((op & m68kd_pkg::MSK_REG_LO) == 16'h0C00)
        begin
            c.mn       = m68kd_pkg::MN_CMPI;
            c.len      = 4'd4;
            c.size     = 3'd1;
            c.form     = m68kd_pkg::FM_IMM_DN;
            c.reg_main = lr;
            c.imm      = {24'd0, e1[7:0]};
        end
        else if (op == m68kd_pkg::OP_ADD_DD)
        begin
            c.mn   = m68kd_pkg::MN_ADD;
            c.size = 3'd2;
            c.form = m68kd_pkg::FM_DN_DN;
        end
        else if ((op & m68kd_pkg::MSK_SUBQ) == 16'h5100 && sz2 != 2'd3)
        begin
            // quick value zero stands for eight
            c.mn       = m68kd_pkg::MN_SUBQ;
            c.form     = m68kd_pkg::FM_DN;
            c.reg_main = lr;
            c.imm      = (hr == 3'd0) ? 32'd8 : {29'd0, hr};
            c.size     = m68kd_pkg::size_bytes(sz2);
        end
        else if (op == m68kd_pkg::OP_CLRB_ABS || op == m68kd_pkg::OP_CLRW_ABS
                 || op == m68kd_pkg::OP_CLRL_ABS)
        begin
            c.mn   = m68kd_pkg::MN_CLR;
            c.len  = 4'd6;
            c.form = m68kd_pkg::FM_ABS;
            c.absa = l12;
            c.size = m68kd_pkg::size_bytes(sz2);
        end
        else if ((op & m68kd_pkg::MSK_CLR_DN) == 16'h4200 && sz2 != 2'd3)
        begin
            c.mn       = m68kd_pkg::MN_CLR;
            c.form     = m68kd_pkg::FM_DN;
            c.reg_main = lr;
            c.size     = m68kd_pkg::size_bytes(sz2);
        end
        else if (op == m68kd_pkg::OP_TSTB_ABS || op == m68kd_pkg::OP_TSTW_ABS
                 || op == m68kd_pkg::OP_TSTL_ABS)
        begin
            c.mn   = m68kd_pkg::MN_TST;
            c.len  = 4'd6;
            c.form = m68kd_pkg::FM_ABS;
            c.absa = l12;
            c.size = m68kd_pkg::size_bytes(sz2);
        end
        else if ((op & m68kd_pkg::MSK_REG_LO) == 16'h4A28)
        begin
            c.mn       = m68kd_pkg::MN_TST;
            c.len      = 4'd4;
            c.size     = 3'd1;
            c.form     = m68kd_pkg::FM_D16_AN;
            c.reg_main = lr;
            c.disp     = e1;
        end

        // relative targets count from the extension word address
        unique case (ts)
            TS_LONG:
            begin
                c.tgt_base = l12;
                c.tgt_off  = '0;
            end
            TS_REL:
            begin
                c.tgt_base = instr.instr_address;
                c.tgt_off  = roff + 17'sd2;
            end
            default:
            begin
                c.tgt_base = '0;
                c.tgt_off  = '0;
            end
        endcase
        ctl = c;
    end

endmodule

@@ sv/m68k_subset_instruction_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m68k_subset_instruction_decoder
// Three-stage pipelined decoder for a subset of 68000 instructions.
// ----------------------------------------------------------------------------
// Takes one instruction window per cycle while the output side is not
// stalled and returns one decode result for each. Stage one classifies
// the opcode and selects the operand fields, stage two forms the branch
// or effective target with a 32-bit add, stage three is the output register.
// Each stage holds its item while the next is full and cannot advance, so a
// stall on the output ripples back only once all three are full.
module m68k_subset_instruction_decoder (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                instr_valid,
    output logic                instr_stall,
    input  m68kd_pkg::instr_t   instr,
    output logic                dec_valid,
    input  logic                dec_stall,
    output m68kd_pkg::dec_t     dec
);

`include "assert_macros.svh"

    m68kd_pkg::ctl_t ctl;

    logic            s1_valid_reg;
    logic            s1_valid_next;
    m68kd_pkg::ctl_t s1_ctl_reg;
    logic            s2_valid_reg;
    logic            s2_valid_next;
    m68kd_pkg::dec_t s2_dec_reg;
    m68kd_pkg::dec_t s2_dec_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    m68kd_pkg::dec_t out_dec_reg;

    logic s1_en;
    logic s2_en;
    logic out_en;

    m68kd_decode u_decode (
        .instr (instr),
        .ctl   (ctl)
    );

    // A stage advances when empty or when its successor advances
    assign out_en      = !out_valid_reg || !dec_stall;
    assign s2_en       = !s2_valid_reg || out_en;
    assign s1_en       = !s1_valid_reg || s2_en;
    assign instr_stall = !s1_en;

    assign s1_valid_next  = s1_en ? instr_valid : s1_valid_reg;
    assign s2_valid_next  = s2_en ? s1_valid_reg : s2_valid_reg;
    assign out_valid_next = out_en ? s2_valid_reg : out_valid_reg;

    always_comb
    begin
        s2_dec_next                    = '0;
        s2_dec_next.mnemonic_code      = s1_ctl_reg.mn;
        s2_dec_next.length_bytes       = s1_ctl_reg.len;
        s2_dec_next.addressing_form    = s1_ctl_reg.form;
        s2_dec_next.operand_size       = s1_ctl_reg.size;
        s2_dec_next.main_register      = s1_ctl_reg.reg_main;
        s2_dec_next.source_register    = s1_ctl_reg.reg_src;
        s2_dec_next.branch_condition   = s1_ctl_reg.cond;
        s2_dec_next.immediate_value    = s1_ctl_reg.imm;
        s2_dec_next.displacement_value = s1_ctl_reg.disp;
        s2_dec_next.absolute_address   = s1_ctl_reg.absa;
        // wrap modulo 2^32
        s2_dec_next.target_address     = s1_ctl_reg.tgt_base
                                       + {{15{s1_ctl_reg.tgt_off[16]}}, s1_ctl_reg.tgt_off};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_en && instr_valid)
        begin
            s1_ctl_reg <= ctl;
        end
        if (s2_en && s1_valid_reg)
        begin
            s2_dec_reg <= s2_dec_next;
        end
        if (out_en && s2_valid_reg)
        begin
            out_dec_reg <= s2_dec_reg;
        end
    end

    assign dec_valid = out_valid_reg;
    assign dec       = out_dec_reg;

    // Input only stalls once every stage holds an item
    `ASSERT_IMPLY(a_stall_full, clk, rst_n, instr_stall,
        s1_valid_reg && s2_valid_reg && out_valid_reg && dec_stall)

    // An unmapped fetch lands in stage one as INVALID with length zero
    `ASSERT_NEXT(a_unmapped, clk, rst_n, instr_valid && !instr_stall && !instr.fetch_mapped,
        s1_valid_reg && s1_ctl_reg.mn == m68kd_pkg::MN_INVALID && s1_ctl_reg.len == 4'd0)

    // A blocked stage-one item is held, not dropped
    `ASSERT_NEXT(a_s1_hold, clk, rst_n, s1_valid_reg && !s2_en,
        s1_valid_reg && $stable(s1_ctl_reg))

    // A blocked stage-two item is held, not dropped
    `ASSERT_NEXT(a_s2_hold, clk, rst_n, s2_valid_reg && !out_en,
        s2_valid_reg && $stable(s2_dec_reg))

endmodule
